// ===== hdl/sat_pkg.sv =====
// Shared types and constants for the seen-address table with ageing.
// No dependencies; every other file in hdl/ imports this package.
package sat_pkg;

	localparam int ADDR_W  = 48;
	localparam int TIME_W  = 48;
	localparam int LIMIT_W = 32;
	localparam int COUNT_W = 6;

	// freed count saturates at the top of its field
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 32'd60000;

	typedef enum logic {
		OP_CHECK = 1'b0,
		OP_SWEEP = 1'b1
	} sat_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_RESP
	} sat_state_t;

	// one table word: valid flag, address and stamp
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] address;
		logic [TIME_W-1:0] stamp;
	} sat_entry_t;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] device_address;
		logic [TIME_W-1:0] current_time;
	} sat_req_t;

	typedef struct packed {
		logic               already_seen;
		logic               newly_stored;
		logic [COUNT_W-1:0] freed_count;
	} sat_rsp_t;

endpackage

// ===== hdl/sat_req_if.sv =====
// Request channel: valid/ready handshake carrying one check or sweep request.
// Depends on sat_pkg for the field widths.
interface sat_req_if import sat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [ADDR_W-1:0] device_address;
	logic [TIME_W-1:0] current_time;

	modport source (output valid, output opcode, output device_address,
		output current_time, input ready);
	modport sink (input valid, input opcode, input device_address,
		input current_time, output ready);
endinterface

// ===== hdl/sat_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result per request.
// Depends on sat_pkg for the field widths.
interface sat_rsp_if import sat_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               already_seen;
	logic               newly_stored;
	logic [COUNT_W-1:0] freed_count;

	modport source (output valid, output already_seen, output newly_stored,
		output freed_count, input ready);
	modport sink (input valid, input already_seen, input newly_stored,
		input freed_count, output ready);
endinterface

// ===== hdl/sat_table_mem.sv =====
// Entry store: one synchronous memory, one write port, one registered read port.
// Depends on sat_pkg for the entry word layout.
module sat_table_mem import sat_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int AW      = 5
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_idx,
	output sat_entry_t    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_idx,
	input  sat_entry_t    wr_data
);

	sat_entry_t mem [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

// ===== hdl/sat_ctrl.sv =====
// Sequencer: clears the store after reset, then walks every entry once per
// request (match / free search or ageing) and commits the result.
// Depends on sat_pkg; drives sat_table_mem.
module sat_ctrl import sat_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int AW      = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] age_limit,
	// request side
	input  logic               in_valid,
	output logic               in_ready,
	input  sat_req_t           in_req,
	// result side
	output logic               res_valid,
	input  logic               res_ready,
	output sat_rsp_t           res,
	// memory
	output logic               rd_en,
	output logic [AW-1:0]      rd_idx,
	input  sat_entry_t         rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_idx,
	output sat_entry_t         wr_data
);

	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	sat_state_t         state_q, state_d;
	logic [AW-1:0]      idx_q;
	logic               pend_s1;
	logic [AW-1:0]      idx_s1;
	logic               op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TIME_W-1:0]  now_q;
	logic               hit_q;
	logic               free_found_q;
	logic [AW-1:0]      free_idx_q;
	logic [COUNT_W-1:0] freed_q;

	logic accept;
	logic aged;
	logic match;
	logic do_store;

	assign accept = in_valid && in_ready;

	// compare of the word coming back from the memory
	assign match = rd_data.valid && (rd_data.address == addr_q);
	assign aged  = rd_data.valid && (now_q > rd_data.stamp)
		&& ((now_q - rd_data.stamp) > {{(TIME_W-LIMIT_W){1'b0}}, age_limit});

	assign do_store = (op_q == OP_CHECK) && !hit_q && free_found_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (idx_q == LAST_IDX) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (idx_q == LAST_IDX) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_RESP;
			ST_RESP:   if (res_ready) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// outputs and memory port control
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESP);
		rd_en     = (state_q == ST_SCAN);
		rd_idx    = idx_q;
		wr_en     = 1'b0;
		wr_idx    = idx_s1;
		wr_data   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en  = 1'b1;
				wr_idx = idx_q;
			end
			ST_SCAN, ST_DRAIN: begin
				// ageing write-back lands one entry behind the read, never the same one
				wr_en = pend_s1 && (op_q == OP_SWEEP) && aged;
			end
			ST_COMMIT: begin
				wr_en   = do_store;
				wr_idx  = free_idx_q;
				wr_data = '{valid: 1'b1, address: addr_q, stamp: now_q};
			end
			default: begin
			end
		endcase
		res.already_seen = (op_q == OP_CHECK) && hit_q;
		res.newly_stored = do_store;
		res.freed_count  = freed_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
		end
	end

	// request and scan accumulators
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			op_q         <= in_req.opcode;
			addr_q       <= in_req.device_address;
			now_q        <= in_req.current_time;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			freed_q      <= '0;
		end else if (pend_s1) begin
			if (op_q == OP_CHECK) begin
				if (match) hit_q <= 1'b1;
				// lowest free entry wins
				if (!rd_data.valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end else if (aged && freed_q != COUNT_MAX) begin
				freed_q <= freed_q + 1'b1;
			end
		end
	end

	// no read and write of the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_idx != wr_idx))
		else $error("read and write hit the same entry");

	// a store only goes to an entry found free in the walk
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && wr_en) |-> (free_found_q && !hit_q))
		else $error("store without a free entry");

	// a check never reports both outcomes
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.already_seen && res.newly_stored))
		else $error("seen and stored together");

	// a check never reports freed entries
	a_check_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && op_q == OP_CHECK) |-> (res.freed_count == '0))
		else $error("freed count on a check");

	// no request is taken while a walk is running
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !in_ready)
		else $error("request accepted mid-walk");

endmodule

// ===== hdl/seen_address_table_with_aging_top.sv =====
// Seen-address table with ageing. Each request walks all ENTRIES table words
// through the single read port of the entry memory; a request goes through
// accept, a read of every entry, a drain step, a commit step and a hand-off
// to the output register before the next one is taken. A check reports
// already_seen on a hit, otherwise stores the address and time in the lowest
// free entry (newly_stored); a full table stores nothing. A sweep frees valid
// entries whose age is strictly above age_limit and reports the count,
// saturating at 63. After reset a clearing pass empties the table; no request
// is accepted until it ends. The output register holds a finished result while
// the next request is accepted. age_limit is written through cfg_we/cfg_wdata;
// the user must only write it while the block is idle; it is not enforced.
//
// Depends on sat_pkg, sat_req_if, sat_rsp_if, sat_table_mem, sat_ctrl.
module seen_address_table_with_aging_top import sat_pkg::*; #(
	parameter int ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	sat_req_if.sink            req,
	sat_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [LIMIT_W-1:0] age_limit_q;
	sat_req_t           in_req;
	logic               res_valid;
	logic               res_ready;
	sat_rsp_t           res;
	sat_rsp_t           rsp_q;
	logic               rsp_valid_q;
	logic               rd_en;
	logic [AW-1:0]      rd_idx;
	sat_entry_t         rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_idx;
	sat_entry_t         wr_data;

	// age limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RESET;
		end else if (cfg_we) begin
			age_limit_q <= cfg_wdata;
		end
	end

	assign in_req = '{opcode: req.opcode, device_address: req.device_address,
		current_time: req.current_time};

	sat_ctrl #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.age_limit(age_limit_q),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_req   (in_req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data)
	);

	sat_table_mem #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_data(wr_data)
	);

	// output register, refilled as it drains
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.already_seen = rsp_q.already_seen;
	assign rsp.newly_stored = rsp_q.newly_stored;
	assign rsp.freed_count  = rsp_q.freed_count;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the seen-address table with ageing: directed table, then
// random phases over several age limits and handshake idling patterns.
// Depends on sat_pkg, sat_req_if, sat_rsp_if and seen_address_table_with_aging_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sat_pkg::*;

	localparam int TABLE_DEPTH   = 32;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = TABLE_DEPTH + 8;
	localparam int LONG_HOLD     = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 232;
	localparam int POOL_SIZE     = 48;

	localparam sat_rsp_t RSP_SEEN   = '{1'b1, 1'b0, 6'd0};
	localparam sat_rsp_t RSP_STORED = '{1'b0, 1'b1, 6'd0};
	localparam sat_rsp_t RSP_NONE   = '{1'b0, 1'b0, 6'd0};

	// one row of the directed part; reps repeats the row with the address counting up
	typedef struct {
		sat_op_t           op;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] now;
		int                reps;
		bit                typed;
		sat_rsp_t          want;
	} probe_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	sat_req_if req_ch ();
	sat_rsp_if rsp_ch ();

	// shadow copy of the table and the age limit
	logic               seen_valid [TABLE_DEPTH];
	logic [ADDR_W-1:0]  seen_addr  [TABLE_DEPTH];
	logic [TIME_W-1:0]  seen_stamp [TABLE_DEPTH];
	logic [LIMIT_W-1:0] age_limit;

	sat_rsp_t           verdicts_due [$];
	logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
	logic [TIME_W-1:0]  clock_ms;
	int                 mismatches = 0;
	int                 cycles_run = 0;
	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	int                 stall_orders = 0;

	probe_row_t probe_rows [18] = '{
		'{OP_CHECK, 48'h0000_0000_0000, 48'd0,              1,  1'b1, RSP_STORED},
		'{OP_CHECK, 48'h0000_0000_0000, 48'd10,             1,  1'b1, RSP_SEEN},
		'{OP_CHECK, 48'hFFFF_FFFF_FFFF, 48'd100,            1,  1'b1, RSP_STORED},
		'{OP_CHECK, 48'hFFFF_FFFF_FFFF, 48'd200,            1,  1'b1, RSP_SEEN},
		// age exactly at the limit is kept
		'{OP_SWEEP, 48'h1234_5678_9ABC, 48'd60000,          1,  1'b1, RSP_NONE},
		'{OP_SWEEP, 48'h0000_0000_0000, 48'd60001,          1,  1'b1, '{1'b0, 1'b0, 6'd1}},
		'{OP_CHECK, 48'hAAAA_AAAA_AAAA, 48'd60001,          1,  1'b1, RSP_STORED},
		'{OP_CHECK, 48'h5555_5555_5555, 48'd60002,          1,  1'b0, RSP_NONE},
		// time running backwards ages nothing
		'{OP_SWEEP, 48'hFFFF_FFFF_FFFF, 48'd3,              1,  1'b1, RSP_NONE},
		'{OP_CHECK, 48'h0000_0000_0000, 48'd3,              1,  1'b1, RSP_STORED},
		'{OP_SWEEP, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 1,  1'b1, '{1'b0, 1'b0, 6'd4}},
		// fill every entry, then a miss on a full table
		'{OP_CHECK, 48'h0000_0000_1000, 48'd1000,   TABLE_DEPTH, 1'b1, RSP_STORED},
		'{OP_CHECK, 48'hDEAD_BEEF_0000, 48'd2000,           1,  1'b1, RSP_NONE},
		'{OP_CHECK, 48'h0000_0000_101F, 48'd2001,           1,  1'b1, RSP_SEEN},
		'{OP_SWEEP, 48'h0000_0000_0000, 48'd61000,          1,  1'b1, RSP_NONE},
		'{OP_CHECK, 48'h0000_0000_1005, 48'd70000,          1,  1'b0, RSP_NONE},
		'{OP_SWEEP, 48'h0000_0000_0000, 48'd61001,          1,  1'b1, '{1'b0, 1'b0, 6'd32}},
		'{OP_CHECK, 48'hDEAD_BEEF_0000, 48'd61001,          1,  1'b1, RSP_STORED}
	};

	seen_address_table_with_aging_top #(
		.ENTRIES(TABLE_DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run == CYCLE_LIMIT) begin
			$display("seen_address_table_with_aging_top verification failed");
			$finish;
		end
	end

	// apply one request to the shadow table and return the result it earns
	function automatic sat_rsp_t shadow_table_apply(input sat_req_t item);
		sat_rsp_t          verdict;
		logic [TIME_W-1:0] age;
		int                slot;
		verdict = RSP_NONE;
		slot = -1;
		if (item.opcode == OP_CHECK) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (seen_valid[i] && seen_addr[i] == item.device_address)
					verdict.already_seen = 1'b1;
			if (!verdict.already_seen) begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (!seen_valid[i] && slot < 0)
						slot = i;
				if (slot >= 0) begin
					seen_valid[slot] = 1'b1;
					seen_addr[slot]  = item.device_address;
					seen_stamp[slot] = item.current_time;
					verdict.newly_stored = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (seen_valid[i]) begin
					age = (item.current_time >= seen_stamp[i]) ?
						item.current_time - seen_stamp[i] : '0;
					if (age > age_limit) begin
						seen_valid[i] = 1'b0;
						if (verdict.freed_count != COUNT_MAX)
							verdict.freed_count = verdict.freed_count + 1'b1;
					end
				end
			end
		end
		return verdict;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[47:0];
	endfunction

	// random request: mostly pool addresses so hits and a full table occur; sweeps
	// often land right at the limit boundary of a live entry
	function automatic sat_req_t random_item();
		sat_req_t    item;
		int          live [$];
		int          pick;
		int unsigned step_max;
		logic [63:0] edge_ms;
		step_max = (age_limit > 4000) ? 1000 : age_limit / 4 + 3;
		item.device_address = ($urandom_range(0, 99) < 85) ?
			addr_pool[$urandom_range(0, POOL_SIZE - 1)] : rand48();
		item.opcode = ($urandom_range(0, 99) < 20) ? OP_SWEEP : OP_CHECK;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (seen_valid[i])
				live.push_back(i);
		pick = $urandom_range(0, 15);
		if (item.opcode == OP_SWEEP && live.size() > 0 && pick < 8) begin
			edge_ms = 64'(seen_stamp[live[$urandom_range(0, live.size() - 1)]]) +
				64'(age_limit) + 64'($urandom_range(0, 2)) - 64'd1;
			item.current_time = edge_ms[TIME_W-1:0];
			if (item.current_time > clock_ms)
				clock_ms = item.current_time;
		end else if (pick == 8) begin
			item.current_time = rand48();
		end else if (pick == 9) begin
			item.current_time = clock_ms - TIME_W'($urandom_range(0, 50));
		end else begin
			clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
			item.current_time = clock_ms;
		end
		return item;
	endfunction

	// offer one request; valid stays high afterwards unless the next one idles
	task automatic offer(input sat_req_t item, input bit typed, input sat_rsp_t want);
		sat_rsp_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.opcode         <= item.opcode;
		req_ch.device_address <= item.device_address;
		req_ch.current_time   <= item.current_time;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = shadow_table_apply(item);
		verdicts_due.push_back(typed ? want : predicted);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_age_limit(input logic [LIMIT_W-1:0] limit);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
		age_limit = limit;
	endtask

	// result receiver: random back-pressure plus an occasional long hold-off
	initial begin
		int hold;
		int served;
		hold = 0;
		served = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (served != stall_orders) begin
				served = stall_orders;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold = hold - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// result checker against the oldest outstanding expectation
	always @(posedge clk) begin
		sat_rsp_t due;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				$error("result with nothing outstanding");
				mismatches++;
			end else begin
				due = verdicts_due.pop_front();
				if (rsp_ch.already_seen !== due.already_seen) begin
					$error("already_seen: expected %0d, got %0d",
						due.already_seen, rsp_ch.already_seen);
					mismatches++;
				end
				if (rsp_ch.newly_stored !== due.newly_stored) begin
					$error("newly_stored: expected %0d, got %0d",
						due.newly_stored, rsp_ch.newly_stored);
					mismatches++;
				end
				if (rsp_ch.freed_count !== due.freed_count) begin
					$error("freed_count: expected %0d, got %0d",
						due.freed_count, rsp_ch.freed_count);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		sat_req_t item;
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.opcode         <= OP_CHECK;
		req_ch.device_address <= '0;
		req_ch.current_time   <= '0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			seen_valid[i] = 1'b0;
		age_limit = AGE_LIMIT_RESET;
		clock_ms = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset age limit, light idling on both sides
		send_idle_pct = 22;
		stall_pct = 22;
		foreach (probe_rows[r]) begin
			for (int k = 0; k < probe_rows[r].reps; k++) begin
				item.opcode         = probe_rows[r].op;
				item.device_address = probe_rows[r].addr + ADDR_W'(k);
				item.current_time   = probe_rows[r].now;
				offer(item, probe_rows[r].typed, probe_rows[r].want);
			end
		end

		// random phases, each with its own age limit and idling pattern
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_age_limit('0);
				1: set_age_limit('1);
				2: set_age_limit(32'd16);
				3: set_age_limit(AGE_LIMIT_RESET);
				4: set_age_limit(LIMIT_W'($urandom_range(1, 300)));
				5: set_age_limit($urandom);
				6: set_age_limit(32'd1);
				default: set_age_limit(32'd100);
			endcase
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 66; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 22; stall_pct = 22; end
			endcase
			foreach (addr_pool[i])
				addr_pool[i] = rand48();
			clock_ms = rand48() >> 4;
			// long receiver hold-off while requests keep coming
			if (phase == 4)
				stall_orders++;
			repeat (PHASE_ITEMS)
				offer(random_item(), 1'b0, RSP_NONE);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("seen_address_table_with_aging_top verification clean");
		else
			$display("seen_address_table_with_aging_top verification failed");
		$finish;
	end

endmodule
